// ----- hw/rtl/hse_pkg.sv -----
package hse_pkg;

    // Default build values.
    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int ALPHABET_SIZE_DEF = 128;

    // Fixed field widths.
    localparam int SYM_W    = 8;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 6;
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int VBITS_W  = 4;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    // Item kinds carried on the input tuser.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    localparam logic [VBITS_W-1:0] FULL_BYTE_BITS = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;     // write the code table entry of the accepted item
        logic align;  // left-align the looked-up code word
        logic step;   // move the next group of code bits into the packer
        logic flush;  // emit the pending partial byte
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sym_ok;     // input symbol lies inside the alphabet
        logic hit;        // looked-up entry holds a code of nonzero length
        logic rem_zero;   // no code bits left for the current item
        logic cnt_zero;   // no bits pending in the packer
        logic slot_free;  // output register can take a byte this cycle
    } t_sts;

endpackage

// ----- hw/rtl/hse_ctrl.sv -----
module hse_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic [hse_pkg::OP_W-1:0] i_op,
    input  hse_pkg::t_sts            i_sts,
    output logic                     o_s_tready,
    output hse_pkg::t_cmd            o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_PACK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        hse_pkg::OP_LOAD: begin
                            o_cmd.wr = i_sts.sym_ok;
                        end
                        hse_pkg::OP_ENCODE: begin
                            if (i_sts.sym_ok) begin
                                n_state = ST_READ;
                            end
                        end
                        hse_pkg::OP_FLUSH: begin
                            n_state = ST_FLUSH;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.align = 1'b1;
                n_state     = i_sts.hit ? ST_PACK : ST_IDLE;
            end
            ST_PACK: begin
                if (i_sts.rem_zero) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.step = i_sts.slot_free;
                end
            end
            ST_FLUSH: begin
                if (i_sts.cnt_zero) begin
                    n_state = ST_IDLE;
                end else if (i_sts.slot_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/hse_datapath.sv -----
module hse_datapath #(
    parameter int MAX_CODE_BITS = hse_pkg::MAX_CODE_BITS_DEF,
    parameter int ALPHABET_SIZE = hse_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [hse_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hse_pkg::WORD_W-1:0]   i_code_word,
    input  logic [hse_pkg::LEN_W-1:0]    i_code_length,
    input  hse_pkg::t_cmd                i_cmd,
    output hse_pkg::t_sts                o_sts,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [hse_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [hse_pkg::VBITS_W-1:0]  o_valid_bits,
    output logic                         o_last
);

    localparam int IW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam int CR = MAX_CODE_BITS + hse_pkg::BYTE_W;
    localparam int AW = MAX_CODE_BITS + hse_pkg::WORD_W;

    // Code table: length and word memories, plus per-entry valid flags so
    // that an entry never loaded reads as empty.
    logic [LW-1:0]                 mem_len  [ALPHABET_SIZE];
    logic [hse_pkg::WORD_W-1:0]    mem_word [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0]      r_vld;

    logic [LW-1:0]                 r_rd_len;
    logic [hse_pkg::WORD_W-1:0]    r_rd_word;
    logic                          r_rd_vld;

    logic [CR-1:0]                 r_code;
    logic [LW-1:0]                 r_rem;
    logic [hse_pkg::BYTE_W-1:0]    r_acc;
    logic [2:0]                    r_cnt;

    logic                          r_m_valid;
    logic [hse_pkg::BYTE_W-1:0]    r_out_byte;
    logic [hse_pkg::VBITS_W-1:0]   r_valid_bits;
    logic                          r_last;

    logic [IW-1:0]                 idx;
    logic [LW-1:0]                 wr_len;
    logic [LW-1:0]                 shamt;
    logic [AW-1:0]                 aligned;
    logic [3:0]                    space;
    logic [7:0]                    rem8;
    logic [3:0]                    take;
    logic [3:0]                    sum;
    logic [LW-1:0]                 rem_after;
    logic [hse_pkg::BYTE_W-1:0]    merged;
    logic                          full;
    logic                          emit;

    assign idx = i_symbol[IW-1:0];

    always_comb begin
        if ({2'b00, i_code_length} > 8'(MAX_CODE_BITS)) begin
            wr_len = LW'(MAX_CODE_BITS);
        end else begin
            wr_len = LW'(i_code_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem_len[idx]  <= wr_len;
            mem_word[idx] <= i_code_word;
        end
        r_rd_len  <= mem_len[idx];
        r_rd_word <= mem_word[idx];
        r_rd_vld  <= r_vld[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr) begin
            r_vld[idx] <= 1'b1;
        end
    end

    // Packer step arithmetic.
    assign shamt     = LW'(MAX_CODE_BITS) - r_rd_len;
    assign aligned   = AW'(r_rd_word) << shamt;
    assign space     = 4'd8 - {1'b0, r_cnt};
    assign rem8      = 8'(r_rem);
    assign take      = (rem8 < 8'(space)) ? rem8[3:0] : space;
    assign sum       = {1'b0, r_cnt} + take;
    assign full      = (sum == 4'd8);
    assign rem_after = r_rem - LW'(take);
    assign merged    = r_acc | (r_code[CR-1 -: hse_pkg::BYTE_W] >> r_cnt);
    assign emit      = (i_cmd.step && full) || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_rem <= '0;
        end else if (i_cmd.align) begin
            r_code <= {aligned[MAX_CODE_BITS-1:0], {hse_pkg::BYTE_W{1'b0}}};
            r_rem  <= r_rd_len;
        end else if (i_cmd.step) begin
            r_code <= r_code << take;
            r_rem  <= rem_after;
            if (full) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                r_acc <= merged;
                r_cnt <= sum[2:0];
            end
        end else if (i_cmd.flush) begin
            r_acc <= '0;
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.flush) begin
            r_out_byte   <= r_acc;
            r_valid_bits <= {1'b0, r_cnt};
            r_last       <= 1'b1;
        end else if (i_cmd.step && full) begin
            r_out_byte   <= merged;
            r_valid_bits <= hse_pkg::FULL_BYTE_BITS;
            r_last       <= (8'(rem_after) < 8'd8);
        end
    end

    assign o_sts.sym_ok    = ({1'b0, i_symbol} < 9'(ALPHABET_SIZE));
    assign o_sts.hit       = r_rd_vld && (r_rd_len != '0);
    assign o_sts.rem_zero  = (r_rem == '0);
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.slot_free = !r_m_valid || i_m_tready;

    assign o_m_tvalid   = r_m_valid;
    assign o_out_byte   = r_out_byte;
    assign o_valid_bits = r_valid_bits;
    assign o_last       = r_last;

endmodule

// ----- hw/rtl/huffman_symbol_encoder.sv -----
// Table-driven Huffman encoder with an MSB-first byte packer. Each input item
// carries its kind on tuser: a load writes one symbol's code word and length
// into the code table (all entries read as empty after reset), an encode
// looks up its symbol and appends the code bits, first bit first, and a flush
// sends the pending partial byte padded with zeros. Every completed byte
// leaves as one output item with the number of meaningful bits from bit 7
// down (8 for full bytes), and tlast marks the last byte caused by an input
// item. Symbols outside the alphabet, empty codes, a flush with nothing
// pending and the unused kind give no output. Codes longer than
// MAX_CODE_BITS are cut to that length when loaded. The block works on one
// item at a time: a load is written as it is accepted, a flush with bits
// pending waits for a free output slot and sends its byte, and an encode
// reads the table, aligns the code word and then moves one group of bits into
// the packer per step (one per output byte plus one for a trailing partial
// byte), then goes idle; a 32-bit code gives at most four bytes. The pace of
// an encode is set by the packer, which moves at most eight bits a cycle
// through a single output register, and a stalled output holds the packer.
module huffman_symbol_encoder #(
    parameter int MAX_CODE_BITS = hse_pkg::MAX_CODE_BITS_DEF,
    parameter int ALPHABET_SIZE = hse_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [7:0] symbol, [39:8] code_word, [45:40] code_length, [47:46] zero
    input  logic [hse_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [1:0] operation
    input  logic [hse_pkg::OP_W-1:0]      i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] out_byte, [11:8] valid_bits, [15:12] zero
    output logic [hse_pkg::M_DATA_W-1:0]  o_m_tdata,
    // last_of_run
    output logic                          o_m_tlast
);

    hse_pkg::t_cmd                  cmd;
    hse_pkg::t_sts                  sts;
    logic [hse_pkg::BYTE_W-1:0]     out_byte;
    logic [hse_pkg::VBITS_W-1:0]    valid_bits;

    hse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    hse_datapath #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_symbol      (i_s_tdata[7:0]),
        .i_code_word   (i_s_tdata[39:8]),
        .i_code_length (i_s_tdata[45:40]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_out_byte    (out_byte),
        .o_valid_bits  (valid_bits),
        .o_last        (o_m_tlast)
    );

    // The upper tdata bits are padding to a whole byte.
    assign o_m_tdata = {4'b0000, valid_bits, out_byte};

endmodule
